### hdl/integer_to_radix_digits_macros.svh
// Assertion macros shared by the integer_to_radix_digits RTL.
// Needs nothing but a clock and a reset name at the point of use.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ITRD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("integer_to_radix_digits: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define ITRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer_to_radix_digits: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_to_radix_digits: sequence violated");

`endif

### hdl/itrd_pkg.sv
// Package for integer_to_radix_digits: widths, constants, command/status types,
// controller state type and digit helper functions. No dependencies.
package itrd_pkg;

   localparam int VALUE_BITS    = 31;
   localparam int STEP_BITS     = 8;   // quotient bits resolved per cycle
   localparam int DIV_CYCLES    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_BITS      = DIV_CYCLES * STEP_BITS;
   localparam int STEP_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int DIGIT_MAX     = VALUE_BITS;
   localparam int CNT_BITS      = $clog2(DIGIT_MAX + 1);
   localparam int IDX_BITS      = (DIGIT_MAX > 1) ? $clog2(DIGIT_MAX) : 1;
   localparam int RADIX_BITS    = 5;
   localparam int DIGIT_BITS    = 4;
   localparam int CHAR_BITS     = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [DIGIT_BITS-1:0] DEC_MAX     = 4'd9;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA  = 7'h41;
   localparam logic [CHAR_BITS-1:0]  ALPHA_BIAS  = 7'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;   // capture a new value and latch the base
      logic step;   // run one slice of the long division
      logic push;   // store the finished remainder as a digit
      logic pop;    // move the top digit into the output register
   } cmd_type;

   typedef struct packed {
      logic step_last;  // current division slice completes the digit
      logic quot_zero;  // quotient after this slice is zero
      logic cnt_one;    // one digit left in the buffer
      logic out_free;   // output register can take a digit this cycle
   } status_type;

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d <= DEC_MAX) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = CHAR_ALPHA + (CHAR_BITS'(d) - ALPHA_BIAS);
      end
      return res;
   endfunction

endpackage

### hdl/itrd_datapath.sv
// Datapath: radix register, sliced long divider, digit stack and output register.
// Depends on itrd_pkg and the assertion macros header.
`include "integer_to_radix_digits_macros.svh"

module itrd_datapath
   import itrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  csr_valid,
   input  logic [RADIX_BITS-1:0] csr_radix,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last_digit
);

   logic [RADIX_BITS-1:0]    radix_ff;
   logic [RADIX_BITS-1:0]    base_ff;
   logic [DIV_BITS-1:0]      div_ff;
   logic [DIV_BITS-1:0]      div_in;
   logic [RADIX_BITS-1:0]    rem_ff;
   logic [RADIX_BITS-1:0]    rem_in;
   logic [STEP_CNT_BITS-1:0] step_ff;
   logic [CNT_BITS-1:0]      count_ff;
   logic [DIGIT_BITS-1:0]    stack_ff [DIGIT_MAX];
   logic [IDX_BITS-1:0]      top_idx;
   logic                     rsp_valid_ff;
   logic [CHAR_BITS-1:0]     char_ff;
   logic                     last_ff;
   logic [RADIX_BITS:0]      trial;

   // Restoring division of one slice: STEP_BITS quotient bits shift in at the bottom.
   always_comb begin
      div_in = div_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial  = {rem_in, div_in[DIV_BITS-1]};
         div_in = {div_in[DIV_BITS-2:0], 1'b0};
         if (trial >= {1'b0, base_ff}) begin
            rem_in    = RADIX_BITS'(trial - {1'b0, base_ff});
            div_in[0] = 1'b1;
         end else begin
            rem_in = trial[RADIX_BITS-1:0];
         end
      end
   end

   assign top_idx = IDX_BITS'(count_ff - CNT_BITS'(1));

   assign status.step_last = (step_ff == STEP_CNT_BITS'(DIV_CYCLES - 1));
   assign status.quot_zero = (div_in == '0);
   assign status.cnt_one   = (count_ff == CNT_BITS'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_radix;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= clamp_radix(radix_ff);
         div_ff  <= DIV_BITS'(req_value);
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.step) begin
         div_ff <= div_in;
         if (status.step_last) begin
            rem_ff  <= '0;
            step_ff <= '0;
         end else begin
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + CNT_BITS'(1);
      end else if (cmd.pop) begin
         count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_ff[count_ff[IDX_BITS-1:0]] <= rem_in[DIGIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         char_ff <= digit_ascii(stack_ff[top_idx]);
         last_ff <= status.cnt_one;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

   `ITRD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_BITS'(DIGIT_MAX))
   `ITRD_ASSERT_IMPLY(a_pop_nonempty, clock, reset, cmd.pop, count_ff != '0 && status.out_free)
   `ITRD_ASSERT_IMPLY(a_rem_below_base, clock, reset, cmd.step, rem_ff < base_ff)
   `ITRD_ASSERT_NEXT(a_load_base, clock, reset, cmd.load,
                     base_ff >= RADIX_MIN && base_ff <= RADIX_MAX)

endmodule

### hdl/itrd_ctrl.sv
// Controller state machine: sequences load, division slices, digit push and emission.
// Depends on itrd_pkg.
module itrd_ctrl
   import itrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // leave once the quotient runs out
            if (status.step_last && status.quot_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.cnt_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            cmd.push = status.step_last;
         end
         ST_EMIT: begin
            cmd.pop = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### hdl/integer_to_radix_digits.sv
// A request is accepted in ST_IDLE; the divider then resolves each digit slice by slice,
// and digits go out one per cycle while rsp_ready keeps the output register free.
// The divider resolves 8 quotient bits per cycle; one item is in work at a time.
// The output register lets the next item be accepted while a digit waits.
// Reset (synchronous, active high) sets radix to 10 and clears the state, digit count and output valid.
module integer_to_radix_digits
   import itrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last_digit,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_BITS-1:0] csr_radix
);

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   itrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itrd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .csr_valid      (csr_valid),
      .csr_radix      (csr_radix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule
